@@ hw/rtl/mset_pkg.sv @@
`default_nettype none
package mset_pkg;

    // Table size and stored tag width.
    localparam int TIMER_SLOTS = 16;
    localparam int TAG_BITS    = 16;

    // Field widths of the channels.
    localparam int TIME_W     = 32;
    localparam int KIND_W     = 2;
    localparam int INTERVAL_W = 31;
    localparam int TAG_W      = 16;
    localparam int STATUS_W   = 2;

    // Derived widths for the slot table.
    localparam int SLOT_TAG_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam int IDX_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TIMER_SLOTS + 1);

    // Input kinds.
    localparam logic [KIND_W-1:0] KIND_ARM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_FIRED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd3;

    // One entry of the slot table.
    typedef struct packed {
        logic [TIME_W-1:0]     expiry;
        logic [SLOT_TAG_W-1:0] tag;
    } t_slot;

    // Request to the shared adder/subtractor.
    typedef struct packed {
        logic              sub;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

endpackage
`default_nettype wire

@@ hw/rtl/mset_in_if.sv @@
`default_nettype none
interface mset_in_if;
    logic                               valid;
    logic                               ready;
    logic [mset_pkg::KIND_W-1:0]        kind;
    logic [mset_pkg::INTERVAL_W-1:0]    interval;
    logic [mset_pkg::TAG_W-1:0]         tag;

    modport source (output valid, kind, interval, tag, input ready);
    modport sink   (input valid, kind, interval, tag, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mset_out_if.sv @@
`default_nettype none
interface mset_out_if;
    logic                               valid;
    logic                               ready;
    logic [mset_pkg::STATUS_W-1:0]      status;
    logic [mset_pkg::TAG_W-1:0]         fired_tag;
    logic                               last;

    modport source (output valid, status, fired_tag, last, input ready);
    modport sink   (input valid, status, fired_tag, last, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/mset_slot_mem.sv @@
`default_nettype none
module mset_slot_mem (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [mset_pkg::IDX_W-1:0] i_waddr,
    input  wire mset_pkg::t_slot            i_wdata,
    input  wire logic [mset_pkg::IDX_W-1:0] i_raddr,
    output mset_pkg::t_slot                 o_rdata
);

    mset_pkg::t_slot r_mem [mset_pkg::TIMER_SLOTS];
    mset_pkg::t_slot r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hw/rtl/mset_alu.sv @@
`default_nettype none
module mset_alu (
    input  wire mset_pkg::t_alu_req             i_req,
    output logic [mset_pkg::TIME_W-1:0]         o_res
);

    // Shared 32-bit adder: expiry on arm, wrapping difference on scan.
    always_comb begin
        if (i_req.sub) begin
            o_res = i_req.a - i_req.b;
        end else begin
            o_res = i_req.a + i_req.b;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/multi_slot_expiry_timer.sv @@
`default_nettype none
// Channel   Port       Direction  Payload
// item      i_item     in         kind, interval, tag
// result    o_result   out        status, fired_tag, last
//
// Arm and clear first update the table, then load the result register once it is free.
// A tick advances the counter, then scans the pending timers: the slot memory is read and
// compared one entry a cycle through the shared adder while no stall holds the scan, and
// then the last fired result is released when any timer expired. An empty table skips the scan.
// Reset is synchronous and active low; it empties the table and zeroes the tick counter.
// A stalled result register holds the scan in place until the result is taken.
module multi_slot_expiry_timer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    mset_in_if.sink         i_item,
    mset_out_if.source      o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_RESP
    } t_state;

    t_state                              r_state;
    logic [mset_pkg::TIME_W-1:0]         r_now;
    logic [mset_pkg::CNT_W-1:0]          r_count;
    logic [mset_pkg::IDX_W-1:0]          r_idx;
    logic [mset_pkg::CNT_W-1:0]          r_keep;
    logic                                r_pend_valid;
    logic [mset_pkg::SLOT_TAG_W-1:0]     r_pend_tag;
    logic [mset_pkg::STATUS_W-1:0]       r_resp_status;
    logic                                r_out_valid;
    logic [mset_pkg::STATUS_W-1:0]       r_out_status;
    logic [mset_pkg::TAG_W-1:0]          r_out_tag;
    logic                                r_out_last;

    logic                                in_fire;
    logic                                out_free;
    logic                                out_load;
    logic                                full;
    logic                                due;
    logic                                stall;
    logic                                scan_last;
    logic [mset_pkg::CNT_W-1:0]          n_keep;
    logic                                mem_we;
    logic [mset_pkg::IDX_W-1:0]          mem_waddr;
    logic [mset_pkg::IDX_W-1:0]          mem_raddr;
    mset_pkg::t_slot                     mem_wdata;
    mset_pkg::t_slot                     mem_rdata;
    mset_pkg::t_alu_req                  alu_req;
    logic [mset_pkg::TIME_W-1:0]         alu_res;

    mset_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mset_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

    // Handshake status.
    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;
    assign full         = (r_count == mset_pkg::CNT_W'(mset_pkg::TIMER_SLOTS));

    // The adder adds the interval in idle and forms now minus expiry while scanning.
    always_comb begin
        alu_req.a = r_now;
        if (r_state == S_SCAN) begin
            alu_req.sub = 1'b1;
            alu_req.b   = mem_rdata.expiry;
        end else begin
            alu_req.sub = 1'b0;
            alu_req.b   = mset_pkg::TIME_W'(i_item.interval);
        end
    end

    // Scan decisions for the slot whose data sits on the memory output.
    assign due       = !alu_res[mset_pkg::TIME_W-1];
    assign stall     = (r_state == S_SCAN) && due && r_pend_valid && !out_free;
    assign scan_last = ((mset_pkg::CNT_W'(r_idx) + mset_pkg::CNT_W'(1)) == r_count);
    assign n_keep    = due ? r_keep : r_keep + mset_pkg::CNT_W'(1);

    // The result register takes a new transaction in this cycle.
    assign out_load  = ((r_state == S_SCAN) && !stall && due && r_pend_valid) ||
                       (((r_state == S_FLUSH) || (r_state == S_RESP)) && out_free);

    // Memory port control: arm writes at the fill count, the scan compacts kept entries.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_keep[mset_pkg::IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                mem_we           = in_fire && (i_item.kind == mset_pkg::KIND_ARM) && !full;
                mem_waddr        = r_count[mset_pkg::IDX_W-1:0];
                mem_wdata.expiry = alu_res;
                mem_wdata.tag    = i_item.tag[mset_pkg::SLOT_TAG_W-1:0];
            end
            S_SCAN: begin
                mem_we    = !stall && !due;
                mem_raddr = stall ? r_idx : r_idx + mset_pkg::IDX_W'(1);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer, table counters and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_result.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_item.kind)
                            mset_pkg::KIND_ARM: begin
                                if (full) begin
                                    r_resp_status <= mset_pkg::ST_FULL;
                                end else begin
                                    r_resp_status <= mset_pkg::ST_ACCEPTED;
                                    r_count       <= r_count + mset_pkg::CNT_W'(1);
                                end
                                r_state <= S_RESP;
                            end
                            mset_pkg::KIND_TICK: begin
                                r_now        <= r_now + mset_pkg::TIME_W'(1);
                                r_idx        <= '0;
                                r_keep       <= '0;
                                r_pend_valid <= 1'b0;
                                r_state      <= (r_count == '0) ? S_IDLE : S_SCAN;
                            end
                            mset_pkg::KIND_CLEAR: begin
                                r_count       <= '0;
                                r_resp_status <= mset_pkg::ST_CLEARED;
                                r_state       <= S_RESP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        // A new due timer releases the previous one as a non-final result.
                        if (due) begin
                            if (r_pend_valid) begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= mset_pkg::ST_FIRED;
                                r_out_tag    <= mset_pkg::TAG_W'(r_pend_tag);
                                r_out_last   <= 1'b0;
                            end
                            r_pend_tag   <= mem_rdata.tag;
                            r_pend_valid <= 1'b1;
                        end
                        r_keep <= n_keep;
                        if (scan_last) begin
                            r_count <= n_keep;
                            r_state <= (r_pend_valid || due) ? S_FLUSH : S_IDLE;
                        end else begin
                            r_idx <= r_idx + mset_pkg::IDX_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    // The held timer is the final one of this tick.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= mset_pkg::ST_FIRED;
                        r_out_tag    <= mset_pkg::TAG_W'(r_pend_tag);
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_resp_status;
                        r_out_tag    <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result channel driven from the output register.
    assign o_result.valid     = r_out_valid;
    assign o_result.status    = r_out_status;
    assign o_result.fired_tag = r_out_tag;
    assign o_result.last      = r_out_last;

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // Kind three carries no meaning; the block must swallow it silently.
    localparam logic [mset_pkg::KIND_W-1:0] KIND_NONE = 2'd3;

    // Traffic phases: which side idles, and how often.
    localparam logic [1:0] PH_SLOW_RX   = 2'd0;
    localparam logic [1:0] PH_SLOW_TX   = 2'd1;
    localparam logic [1:0] PH_FULL_RATE = 2'd2;

    localparam int CYCLE_NS     = 8;
    localparam int RANDOM_ITEMS = 130;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;

    typedef struct packed {
        logic [mset_pkg::KIND_W-1:0]     kind;
        logic [mset_pkg::INTERVAL_W-1:0] interval;
        logic [mset_pkg::TAG_W-1:0]      tag;
        logic [1:0]                      phase;
    } t_item;

    typedef struct packed {
        logic [mset_pkg::STATUS_W-1:0] status;
        logic [mset_pkg::TAG_W-1:0]    fired_tag;
        logic                          last;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mset_in_if  item_bus ();
    mset_out_if result_bus ();

    // Testbench-side drivers of the two channels.
    t_item bus_item   = '0;
    logic  drv_valid  = 1'b0;
    logic  take_ready = 1'b0;

    assign item_bus.valid    = drv_valid;
    assign item_bus.kind     = bus_item.kind;
    assign item_bus.interval = bus_item.interval;
    assign item_bus.tag      = bus_item.tag;
    assign result_bus.ready  = take_ready;

    multi_slot_expiry_timer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    // Stimulus backlog, expected results and the predicted timer table.
    t_item                       item_backlog [$];
    t_result                     owed_results [$];
    mset_pkg::t_slot             armed_timers [$];
    logic [mset_pkg::TIME_W-1:0] model_now = '0;

    int n_items_total = 0;
    int n_accepted    = 0;
    int n_fail        = 0;
    int n_taken       = 0;
    int hold_left     = 0;
    bit hold_used     = 1'b0;

    initial begin
        forever #(CYCLE_NS / 2) i_clk = ~i_clk;
    end

    // Idle percentage of one side in a given traffic phase.
    function automatic int unsigned idle_pct(input logic [1:0] ph, input logic sender);
        case (ph)
            PH_SLOW_RX: return sender ? 27 : 69;
            PH_SLOW_TX: return sender ? 69 : 27;
            default:    return 0;
        endcase
    endfunction

    // Apply one accepted item to the predicted table and queue what it must produce.
    function automatic void advance_timer_table(input t_item it);
        mset_pkg::t_slot             kept [$];
        logic [mset_pkg::TIME_W-1:0] diff;
        int                          n_due;
        int                          n_out;
        n_due = 0;
        n_out = 0;
        case (it.kind)
            mset_pkg::KIND_ARM: begin
                if (armed_timers.size() >= mset_pkg::TIMER_SLOTS) begin
                    owed_results.push_back('{status: mset_pkg::ST_FULL, fired_tag: '0,
                                             last: 1'b1});
                end else begin
                    armed_timers.push_back('{
                        expiry: model_now + mset_pkg::TIME_W'(it.interval),
                        tag: it.tag[mset_pkg::SLOT_TAG_W-1:0]});
                    owed_results.push_back('{status: mset_pkg::ST_ACCEPTED, fired_tag: '0,
                                             last: 1'b1});
                end
            end
            mset_pkg::KIND_TICK: begin
                model_now = model_now + 1'b1;
                // A timer is due when now - expiry is non-negative as a signed value.
                foreach (armed_timers[i]) begin
                    diff = model_now - armed_timers[i].expiry;
                    if (!diff[mset_pkg::TIME_W-1]) n_due++;
                end
                foreach (armed_timers[i]) begin
                    diff = model_now - armed_timers[i].expiry;
                    if (!diff[mset_pkg::TIME_W-1]) begin
                        n_out++;
                        owed_results.push_back('{status: mset_pkg::ST_FIRED,
                                                 fired_tag: mset_pkg::TAG_W'(armed_timers[i].tag),
                                                 last: (n_out == n_due)});
                    end else begin
                        kept.push_back(armed_timers[i]);
                    end
                end
                armed_timers = kept;
            end
            mset_pkg::KIND_CLEAR: begin
                armed_timers.delete();
                owed_results.push_back('{status: mset_pkg::ST_CLEARED, fired_tag: '0,
                                         last: 1'b1});
            end
            default: begin
            end
        endcase
    endfunction

    task automatic queue_item(input logic [mset_pkg::KIND_W-1:0] k,
                              input logic [mset_pkg::INTERVAL_W-1:0] iv,
                              input logic [mset_pkg::TAG_W-1:0] tg);
        item_backlog.push_back('{kind: k, interval: iv, tag: tg, phase: PH_SLOW_RX});
    endtask

    // Random traffic: mostly arms with short intervals and ticks, so the table
    // fills, overflows and drains; some long intervals, clears and junk kinds.
    task automatic queue_random(input int count, input logic [1:0] ph);
        t_item       it;
        int unsigned roll;
        int          made;
        made = 0;
        while (made < count) begin
            roll        = $urandom_range(99);
            it.tag      = mset_pkg::TAG_W'($urandom);
            it.interval = mset_pkg::INTERVAL_W'($urandom_range(12));
            it.phase    = ph;
            if (roll < 50)      it.kind = mset_pkg::KIND_ARM;
            else if (roll < 92) it.kind = mset_pkg::KIND_TICK;
            else if (roll < 96) it.kind = mset_pkg::KIND_CLEAR;
            else                it.kind = KIND_NONE;
            if (it.kind != mset_pkg::KIND_ARM || $urandom_range(9) == 0)
                it.interval = mset_pkg::INTERVAL_W'($urandom);
            if (it.kind != KIND_NONE) made++;
            item_backlog.push_back(it);
        end
    endtask

    // Build the stimulus, release reset, then wait for everything to drain.
    initial begin
        int waited;

        // Directed part: field extremes, the junk kind, an empty tick,
        // a full table, a sixteen-result tick and a clear of an empty table.
        queue_item(mset_pkg::KIND_ARM, '0, 16'hFFFF);
        queue_item(mset_pkg::KIND_ARM, '1, '0);
        queue_item(KIND_NONE, '1, 16'hFFFF);
        queue_item(mset_pkg::KIND_TICK, '0, '0);
        queue_item(mset_pkg::KIND_TICK, '1, 16'hFFFF);
        queue_item(mset_pkg::KIND_CLEAR, '1, 16'hFFFF);
        for (int i = 0; i < mset_pkg::TIMER_SLOTS; i++)
            queue_item(mset_pkg::KIND_ARM, mset_pkg::INTERVAL_W'(i % 2),
                       mset_pkg::TAG_W'(16'h5A00 + i));
        queue_item(mset_pkg::KIND_ARM, '0, 16'hBEEF);
        queue_item(mset_pkg::KIND_TICK, '0, '0);
        queue_item(mset_pkg::KIND_CLEAR, '0, '0);

        queue_random(RANDOM_ITEMS, PH_SLOW_RX);
        queue_random(RANDOM_ITEMS, PH_SLOW_TX);
        queue_random(RANDOM_ITEMS, PH_FULL_RATE);
        n_items_total = item_backlog.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_items_total) @(posedge i_clk);
        waited = 0;
        while (owed_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (owed_results.size() != 0) begin
            $error("%0d expected results never arrived", owed_results.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Driver: present the next backlog item when the channel is free, idling at random by phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && item_bus.ready) begin
                advance_timer_table(bus_item);
                n_accepted <= n_accepted + 1;
            end
            if (!drv_valid || item_bus.ready) begin
                if (item_backlog.size() != 0 &&
                    $urandom_range(99) >= idle_pct(item_backlog[0].phase, 1'b1)) begin
                    bus_item  <= item_backlog.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Monitor: check each result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (result_bus.valid && take_ready) begin
                n_taken <= n_taken + 1;
                if (owed_results.size() == 0) begin
                    $error("unexpected result: status %0d fired_tag %h last %0d",
                           result_bus.status, result_bus.fired_tag, result_bus.last);
                    n_fail++;
                end else begin
                    want = owed_results.pop_front();
                    if (result_bus.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, result_bus.status);
                        n_fail++;
                    end
                    if (result_bus.fired_tag !== want.fired_tag) begin
                        $error("fired_tag: expected %h, got %h",
                               want.fired_tag, result_bus.fired_tag);
                        n_fail++;
                    end
                    if (result_bus.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, result_bus.last);
                        n_fail++;
                    end
                end
            end

            take_ready <= (hold_left == 0) &&
                          ($urandom_range(99) >= idle_pct(bus_item.phase, 1'b0));
        end
    end

    // Watchdog against a hung run.
    initial begin
        #(CYCLE_NS * 700000);
        $display("simulation failed");
        $finish;
    end

endmodule

@@ multi_slot_expiry_timer.f @@
hw/rtl/mset_pkg.sv
hw/rtl/mset_in_if.sv
hw/rtl/mset_out_if.sv
hw/rtl/mset_slot_mem.sv
hw/rtl/mset_alu.sv
hw/rtl/multi_slot_expiry_timer.sv
verif/tb.sv
